>>> rtl/core/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared constants, codes and types of the quad motor mixer with bridge
// sequencer.
// ----------------------------------------------------------------------------
package qmm_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int MOT_IDX_W   = $clog2(MOTOR_COUNT);
    localparam int FRAC_BITS   = 12;
    localparam int TIME_WIDTH  = 32;
    localparam int Q_ONE       = 1 << FRAC_BITS;

    // field widths
    localparam int DEAD_W   = 20;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int STK_W    = 14;
    localparam int THRIN_W  = 13;
    localparam int PID_W    = 16;
    localparam int OUT_W    = 13;

    // throttle map: (11 * t - 1.0 + 5) / 10
    localparam int THR_W      = 14;
    localparam int THR_RND    = 5;
    localparam int THR_EPS    = (Q_ONE + 999) / 1000;
    localparam int DIV10_MUL  = 52429;
    localparam int DIV10_SH   = 19;

    // thrust curve, 16-bit fraction coefficients
    localparam int    X_W        = FRAC_BITS + 1;
    localparam int    H_W        = FRAC_BITS + 17;
    localparam int    P_W        = X_W + H_W;
    localparam int    SUM_W      = X_W + 2;
    localparam int    CURVE_A    = 18153;
    localparam int    CURVE_B    = 46858;
    localparam int    CURVE_C    = 668;
    localparam longint CURVE_BQ  = longint'(CURVE_B) * Q_ONE;
    localparam longint CURVE_CQ  = longint'(CURVE_C) * Q_ONE * Q_ONE;
    localparam longint CURVE_RND = longint'(1) << (FRAC_BITS + 15);
    localparam int    CURVE_SH   = FRAC_BITS + 16;
    localparam int    MOTOR_MAX  = 4105;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_TIME   = 2'd0,
        CFG_STICK_CHECK = 2'd1,
        CFG_FILTER_EN   = 2'd2,
        CFG_INVERT_YAW  = 2'd3
    } t_cfg_idx;

    // bridge stage and drive codes share one encoding
    typedef enum logic [1:0] {
        STG_FWD  = 2'd0,
        STG_REV  = 2'd1,
        STG_WAIT = 2'd2
    } t_stage;

    typedef struct packed {
        logic                 load_in;
        logic                 do_thr;
        logic                 do_mix;
        logic                 mot_a;
        logic [MOT_IDX_W-1:0] mot_a_idx;
        logic                 mot_b;
        logic [MOT_IDX_W-1:0] mot_b_idx;
        logic                 load_out;
    } t_dp_cmd;

endpackage

>>> rtl/core/qmm_in_if.sv
// ----------------------------------------------------------------------------
// qmm_in_if
// Control tick request channel: valid, ready and the tick fields.
// ----------------------------------------------------------------------------
interface qmm_in_if;
    logic                               valid;
    logic                               ready;
    logic                               want_inverted;
    logic [qmm_pkg::TIME_WIDTH-1:0]     now_us;
    logic [qmm_pkg::THRIN_W-1:0]        throttle_stick;
    logic signed [qmm_pkg::STK_W-1:0]   roll_stick;
    logic signed [qmm_pkg::STK_W-1:0]   pitch_stick;
    logic                               failsafe_active;
    logic signed [qmm_pkg::PID_W-1:0]   pid_roll;
    logic signed [qmm_pkg::PID_W-1:0]   pid_pitch;
    logic signed [qmm_pkg::PID_W-1:0]   pid_yaw;

    modport source (
        output valid, want_inverted, now_us, throttle_stick, roll_stick,
               pitch_stick, failsafe_active, pid_roll, pid_pitch, pid_yaw,
        input  ready
    );
    modport sink (
        input  valid, want_inverted, now_us, throttle_stick, roll_stick,
               pitch_stick, failsafe_active, pid_roll, pid_pitch, pid_yaw,
        output ready
    );
endinterface

>>> rtl/core/qmm_out_if.sv
// ----------------------------------------------------------------------------
// qmm_out_if
// Result request channel: valid, ready and the motor and bridge fields.
// ----------------------------------------------------------------------------
interface qmm_out_if;
    logic                        valid;
    logic                        ready;
    logic [qmm_pkg::OUT_W-1:0]   motor_front_right;
    logic [qmm_pkg::OUT_W-1:0]   motor_front_left;
    logic [qmm_pkg::OUT_W-1:0]   motor_back_right;
    logic [qmm_pkg::OUT_W-1:0]   motor_back_left;
    logic [1:0]                  bridge_drive;
    logic                        on_ground;
    logic [qmm_pkg::OUT_W-1:0]   thrust_average;

    modport source (
        output valid, motor_front_right, motor_front_left, motor_back_right,
               motor_back_left, bridge_drive, on_ground, thrust_average,
        input  ready
    );
    modport sink (
        input  valid, motor_front_right, motor_front_left, motor_back_right,
               motor_back_left, bridge_drive, on_ground, thrust_average,
        output ready
    );
endinterface

>>> rtl/core/qmm_ctrl.sv
// ----------------------------------------------------------------------------
// qmm_ctrl
// Tick sequencer: steps the datapath through throttle, mix, four motor
// passes and the result load, and owns the request handshakes.
// ----------------------------------------------------------------------------
module qmm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output qmm_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_MIX,
        S_MOT,
        S_TAIL,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [qmm_pkg::MOT_IDX_W-1:0] r_cnt;
    logic                          r_out_valid;
    logic                          load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign load_out    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.do_thr    = (r_state == S_THR);
        o_cmd.do_mix    = (r_state == S_MIX);
        o_cmd.mot_a     = (r_state == S_MOT);
        o_cmd.mot_a_idx = r_cnt;
        o_cmd.mot_b     = ((r_state == S_MOT) && (r_cnt != '0)) || (r_state == S_TAIL);
        o_cmd.mot_b_idx = r_cnt - 1'b1;
        o_cmd.load_out  = load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_cnt   <= '0;
                    r_state <= S_MOT;
                end
                S_MOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == qmm_pkg::MOT_IDX_W'(qmm_pkg::MOTOR_COUNT - 1)) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/qmm_dp.sv
// ----------------------------------------------------------------------------
// qmm_dp
// Datapath: configuration registers, bridge sequencer, throttle map, quad-X
// mix, per-motor Hann filter and a shared two-stage thrust curve unit.
// ----------------------------------------------------------------------------
module qmm_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  qmm_pkg::t_dp_cmd                      i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [qmm_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_want_inverted,
    input  logic [qmm_pkg::TIME_WIDTH-1:0]        i_now_us,
    input  logic [qmm_pkg::THRIN_W-1:0]           i_throttle_stick,
    input  logic signed [qmm_pkg::STK_W-1:0]      i_roll_stick,
    input  logic signed [qmm_pkg::STK_W-1:0]      i_pitch_stick,
    input  logic                                  i_failsafe_active,
    input  logic signed [qmm_pkg::PID_W-1:0]      i_pid_roll,
    input  logic signed [qmm_pkg::PID_W-1:0]      i_pid_pitch,
    input  logic signed [qmm_pkg::PID_W-1:0]      i_pid_yaw,
    output logic [qmm_pkg::OUT_W-1:0]             o_motor [qmm_pkg::MOTOR_COUNT],
    output logic [1:0]                            o_bridge_drive,
    output logic                                  o_on_ground,
    output logic [qmm_pkg::OUT_W-1:0]             o_thrust_average
);

    localparam int MIX_W = 20;
    localparam int FS_W  = qmm_pkg::PID_W + 2;
    localparam logic signed [qmm_pkg::STK_W-1:0] HALF_STK =
        qmm_pkg::STK_W'(qmm_pkg::Q_ONE / 2);

    function automatic logic signed [qmm_pkg::PID_W-1:0] sat16(
        input logic signed [MIX_W-1:0] v
    );
        logic signed [MIX_W-1:0] hi;
        logic signed [MIX_W-1:0] lo;
        hi = MIX_W'(32767);
        lo = -MIX_W'(32768);
        if (v > hi) begin
            return qmm_pkg::PID_W'(hi);
        end else if (v < lo) begin
            return qmm_pkg::PID_W'(lo);
        end
        return qmm_pkg::PID_W'(v);
    endfunction

    // configuration
    logic [qmm_pkg::DEAD_W-1:0]      r_dead_time;
    logic                            r_stick_chk;
    logic                            r_filt_en;
    logic                            r_inv_yaw;

    // bridge sequencer state
    qmm_pkg::t_stage                 r_stage;
    qmm_pkg::t_stage                 r_drive;
    logic [qmm_pkg::TIME_WIDTH-1:0]  r_wait_start;
    qmm_pkg::t_stage                 n_stage;
    qmm_pkg::t_stage                 n_drive;
    logic [qmm_pkg::TIME_WIDTH-1:0]  n_wait_start;

    // filter state
    logic signed [qmm_pkg::PID_W-1:0] r_flt_last [qmm_pkg::MOTOR_COUNT];
    logic signed [qmm_pkg::PID_W-1:0] r_flt_prev [qmm_pkg::MOTOR_COUNT];

    // latched tick
    logic [qmm_pkg::THRIN_W-1:0]      r_throttle;
    logic signed [qmm_pkg::STK_W-1:0] r_roll_stk;
    logic signed [qmm_pkg::STK_W-1:0] r_pitch_stk;
    logic                             r_failsafe;
    logic signed [qmm_pkg::PID_W-1:0] r_pid_roll;
    logic signed [qmm_pkg::PID_W-1:0] r_pid_pitch;
    logic signed [qmm_pkg::PID_W-1:0] r_pid_yaw;

    // working registers
    logic [qmm_pkg::THR_W-1:0]        r_thr;
    logic                             r_off;
    logic signed [qmm_pkg::PID_W-1:0] r_mix [qmm_pkg::MOTOR_COUNT];
    logic [qmm_pkg::X_W-1:0]          r_x;
    logic [qmm_pkg::H_W-1:0]          r_h;
    logic [qmm_pkg::SUM_W-1:0]        r_sum;
    logic [qmm_pkg::OUT_W-1:0]        r_res [qmm_pkg::MOTOR_COUNT];

    // result registers
    logic [qmm_pkg::OUT_W-1:0]        r_o_motor [qmm_pkg::MOTOR_COUNT];
    logic [1:0]                       r_o_drive;
    logic                             r_o_ground;
    logic [qmm_pkg::OUT_W-1:0]        r_o_avg;

    // ---------------- bridge sequencer
    qmm_pkg::t_stage                 seq_target;
    qmm_pkg::t_stage                 seq_opposite;
    logic [qmm_pkg::TIME_WIDTH-1:0]  seq_elapsed;

    always_comb begin
        seq_target   = i_want_inverted ? qmm_pkg::STG_REV : qmm_pkg::STG_FWD;
        seq_opposite = i_want_inverted ? qmm_pkg::STG_FWD : qmm_pkg::STG_REV;
        n_stage      = r_stage;
        n_drive      = r_drive;
        n_wait_start = r_wait_start;
        if (r_stage != seq_target) begin
            if (r_stage == seq_opposite) begin
                n_stage      = qmm_pkg::STG_WAIT;
                n_wait_start = i_now_us;
                n_drive      = qmm_pkg::STG_WAIT;
            end
        end
        seq_elapsed = i_now_us - n_wait_start;
        if ((r_stage != seq_target) && (n_stage == qmm_pkg::STG_WAIT)) begin
            if (seq_elapsed > qmm_pkg::TIME_WIDTH'(r_dead_time)) begin
                n_stage = seq_target;
                n_drive = seq_target;
            end
        end
    end

    // ---------------- throttle map
    logic [16:0]               thr_x11;
    logic signed [17:0]        thr_raw;
    logic [16:0]               thr_num;
    logic [33:0]               thr_prod;
    logic [qmm_pkg::THR_W-1:0] n_thr;

    always_comb begin
        thr_x11  = {1'b0, r_throttle, 3'b000} + {3'b000, r_throttle, 1'b0}
                 + {4'b0000, r_throttle};
        thr_raw  = $signed({1'b0, thr_x11}) - 18'(qmm_pkg::Q_ONE);
        thr_num  = thr_raw[16:0] + 17'(qmm_pkg::THR_RND);
        thr_prod = 34'(thr_num) * 34'(qmm_pkg::DIV10_MUL);
        n_thr    = thr_raw[17] ? '0 : thr_prod[qmm_pkg::DIV10_SH +: qmm_pkg::THR_W];
    end

    // ---------------- off decision and mix
    logic                     centred;
    logic                     n_off;
    logic signed [MIX_W-1:0]  mx_thr;
    logic signed [MIX_W-1:0]  mx_r;
    logic signed [MIX_W-1:0]  mx_p;
    logic signed [MIX_W-1:0]  mx_y;
    logic signed [MIX_W-1:0]  mx_sum [qmm_pkg::MOTOR_COUNT];

    always_comb begin
        centred = (r_roll_stk < HALF_STK) && (r_roll_stk > -HALF_STK)
               && (r_pitch_stk < HALF_STK) && (r_pitch_stk > -HALF_STK);
        n_off   = r_failsafe || ((r_thr < qmm_pkg::THR_W'(qmm_pkg::THR_EPS))
               && (!r_stick_chk || centred));
        mx_thr  = $signed({{(MIX_W - qmm_pkg::THR_W){1'b0}}, r_thr});
        mx_r    = -MIX_W'(r_pid_roll);
        mx_p    = (r_drive == qmm_pkg::STG_REV) ? -MIX_W'(r_pid_pitch) : MIX_W'(r_pid_pitch);
        mx_y    = r_inv_yaw ? -MIX_W'(r_pid_yaw) : MIX_W'(r_pid_yaw);
        mx_sum[0] = mx_thr - mx_r - mx_p + mx_y;
        mx_sum[1] = mx_thr + mx_r - mx_p - mx_y;
        mx_sum[2] = mx_thr - mx_r + mx_p - mx_y;
        mx_sum[3] = mx_thr + mx_r + mx_p + mx_y;
    end

    // ---------------- motor pass, stage a: filter, clamp, curve inner term
    logic signed [qmm_pkg::PID_W-1:0] f_in;
    logic signed [FS_W-1:0]           f_sum;
    logic signed [qmm_pkg::PID_W-1:0] f_out;
    logic signed [qmm_pkg::PID_W-1:0] f_m;
    logic [qmm_pkg::X_W-1:0]          cv_x;
    logic [qmm_pkg::H_W-1:0]          cv_h;

    always_comb begin
        f_in  = r_off ? '0 : r_mix[i_cmd.mot_a_idx];
        f_sum = FS_W'(f_in) + (FS_W'(r_flt_last[i_cmd.mot_a_idx]) <<< 1)
              + FS_W'(r_flt_prev[i_cmd.mot_a_idx]) + FS_W'(2);
        f_out = qmm_pkg::PID_W'(f_sum >>> 2);
        f_m   = r_filt_en ? f_out : f_in;
        if (f_m[qmm_pkg::PID_W-1]) begin
            cv_x = '0;
        end else if (f_m > qmm_pkg::PID_W'(qmm_pkg::Q_ONE)) begin
            cv_x = qmm_pkg::X_W'(qmm_pkg::Q_ONE);
        end else begin
            cv_x = f_m[qmm_pkg::X_W-1:0];
        end
        cv_h = qmm_pkg::H_W'(qmm_pkg::CURVE_A) * qmm_pkg::H_W'(cv_x)
             + qmm_pkg::H_W'(qmm_pkg::CURVE_BQ);
    end

    // ---------------- motor pass, stage b: outer product and rounding
    logic [qmm_pkg::P_W-1:0] cv_num;

    always_comb begin
        cv_num = qmm_pkg::P_W'(r_x) * qmm_pkg::P_W'(r_h)
               + qmm_pkg::P_W'(qmm_pkg::CURVE_CQ + qmm_pkg::CURVE_RND);
    end

    // ---------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time  <= qmm_pkg::DEAD_W'(4000);
            r_stick_chk  <= 1'b1;
            r_filt_en    <= 1'b1;
            r_inv_yaw    <= 1'b0;
            r_stage      <= qmm_pkg::STG_FWD;
            r_drive      <= qmm_pkg::STG_FWD;
            r_wait_start <= '0;
            for (int k = 0; k < qmm_pkg::MOTOR_COUNT; k++) begin
                r_flt_last[k] <= '0;
                r_flt_prev[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (qmm_pkg::t_cfg_idx'(i_cfg_idx))
                    qmm_pkg::CFG_DEAD_TIME:   r_dead_time <= i_cfg_data[qmm_pkg::DEAD_W-1:0];
                    qmm_pkg::CFG_STICK_CHECK: r_stick_chk <= i_cfg_data[0];
                    qmm_pkg::CFG_FILTER_EN:   r_filt_en   <= i_cfg_data[0];
                    qmm_pkg::CFG_INVERT_YAW:  r_inv_yaw   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_stage      <= n_stage;
                r_drive      <= n_drive;
                r_wait_start <= n_wait_start;
            end
            if (i_cmd.mot_a && r_filt_en) begin
                r_flt_prev[i_cmd.mot_a_idx] <= r_flt_last[i_cmd.mot_a_idx];
                r_flt_last[i_cmd.mot_a_idx] <= f_in;
            end
        end
    end

    // ---------------- payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_throttle  <= i_throttle_stick;
            r_roll_stk  <= i_roll_stick;
            r_pitch_stk <= i_pitch_stick;
            r_failsafe  <= i_failsafe_active;
            r_pid_roll  <= i_pid_roll;
            r_pid_pitch <= i_pid_pitch;
            r_pid_yaw   <= i_pid_yaw;
        end
        if (i_cmd.do_thr) begin
            r_thr <= n_thr;
        end
        if (i_cmd.do_mix) begin
            r_off <= n_off;
            for (int k = 0; k < qmm_pkg::MOTOR_COUNT; k++) begin
                r_mix[k] <= sat16(mx_sum[k]);
            end
        end
        if (i_cmd.mot_a) begin
            r_x <= cv_x;
            r_h <= cv_h;
            if (i_cmd.mot_a_idx == '0) begin
                r_sum <= qmm_pkg::SUM_W'(cv_x);
            end else begin
                r_sum <= r_sum + qmm_pkg::SUM_W'(cv_x);
            end
        end
        if (i_cmd.mot_b) begin
            r_res[i_cmd.mot_b_idx] <= cv_num[qmm_pkg::CURVE_SH +: qmm_pkg::OUT_W];
        end
        if (i_cmd.load_out) begin
            for (int k = 0; k < qmm_pkg::MOTOR_COUNT; k++) begin
                r_o_motor[k] <= r_off ? '0 : r_res[k];
            end
            r_o_drive  <= r_drive;
            r_o_ground <= r_off || (r_stage == qmm_pkg::STG_WAIT);
            r_o_avg    <= r_off ? '0 : r_sum[2 +: qmm_pkg::OUT_W];
        end
    end

    assign o_motor          = r_o_motor;
    assign o_bridge_drive   = r_o_drive;
    assign o_on_ground      = r_o_ground;
    assign o_thrust_average = r_o_avg;

endmodule

>>> rtl/core/quad_motor_mixer_bridge.sv
// an accepted request steps through the throttle, mix, motor, tail and done states
// before its result is valid; a new request is taken only back in idle, and the single
//   curve unit walks the four motors one per cycle after the throttle and mix steps
// a finished result waits in the output register while the next tick runs
// synchronous reset: config to defaults, bridge forward, filters zeroed
// ----------------------------------------------------------------------------
// quad_motor_mixer_bridge
// Quad-X motor mixer behind an H-bridge direction sequencer with dead time.
// ----------------------------------------------------------------------------
module quad_motor_mixer_bridge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    qmm_in_if.sink                        i_in,
    qmm_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [qmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qmm_pkg::CFG_W-1:0]     i_cfg_data
);

    qmm_pkg::t_dp_cmd           cmd;
    logic [qmm_pkg::OUT_W-1:0]  motor [qmm_pkg::MOTOR_COUNT];

    qmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    qmm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_want_inverted   (i_in.want_inverted),
        .i_now_us          (i_in.now_us),
        .i_throttle_stick  (i_in.throttle_stick),
        .i_roll_stick      (i_in.roll_stick),
        .i_pitch_stick     (i_in.pitch_stick),
        .i_failsafe_active (i_in.failsafe_active),
        .i_pid_roll        (i_in.pid_roll),
        .i_pid_pitch       (i_in.pid_pitch),
        .i_pid_yaw         (i_in.pid_yaw),
        .o_motor           (motor),
        .o_bridge_drive    (o_out.bridge_drive),
        .o_on_ground       (o_out.on_ground),
        .o_thrust_average  (o_out.thrust_average)
    );

    assign o_out.motor_front_right = motor[0];
    assign o_out.motor_front_left  = motor[1];
    assign o_out.motor_back_right  = motor[2];
    assign o_out.motor_back_left   = motor[3];

endmodule

>>> rtl/core/qmm_checker.sv
// ----------------------------------------------------------------------------
// qmm_checker
// Port-level checks of the mixer: reset, one tick in flight, result hold
// and result ranges.
// ----------------------------------------------------------------------------
module qmm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [qmm_pkg::OUT_W-1:0]  i_fr,
    input logic [qmm_pkg::OUT_W-1:0]  i_fl,
    input logic [qmm_pkg::OUT_W-1:0]  i_br,
    input logic [qmm_pkg::OUT_W-1:0]  i_bl,
    input logic [1:0]                 i_drive,
    input logic                       i_ground,
    input logic [qmm_pkg::OUT_W-1:0]  i_avg
);

    // after reset the block is empty and open for a request
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not empty after reset");

    // one tick in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fr) && $stable(i_fl)
            && $stable(i_br) && $stable(i_bl) && $stable(i_avg) && $stable(i_drive)
            && $stable(i_ground))
        else $error("result changed while stalled");

    // level ranges and free-wheel implies on ground
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fr <= qmm_pkg::OUT_W'(qmm_pkg::MOTOR_MAX))
            && (i_fl <= qmm_pkg::OUT_W'(qmm_pkg::MOTOR_MAX))
            && (i_br <= qmm_pkg::OUT_W'(qmm_pkg::MOTOR_MAX))
            && (i_bl <= qmm_pkg::OUT_W'(qmm_pkg::MOTOR_MAX))
            && (i_avg <= qmm_pkg::OUT_W'(qmm_pkg::Q_ONE))
            && ((i_drive != 2'(qmm_pkg::STG_WAIT)) || i_ground))
        else $error("result out of range");

endmodule

bind quad_motor_mixer_bridge qmm_checker u_qmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_fr        (o_out.motor_front_right),
    .i_fl        (o_out.motor_front_left),
    .i_br        (o_out.motor_back_right),
    .i_bl        (o_out.motor_back_left),
    .i_drive     (o_out.bridge_drive),
    .i_ground    (o_out.on_ground),
    .i_avg       (o_out.thrust_average)
);
